// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Item and result payloads, operation and character codes, sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [6:0] col;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } t_out_item;

    typedef struct packed {
        logic chr;
        logic atr;
    } t_mem_we;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_DONE
    } t_state;

    localparam logic [2:0] OP_PUT        = 3'd0;
    localparam logic [2:0] OP_PUT_ATTR   = 3'd1;
    localparam logic [2:0] OP_CLEAR      = 3'd2;
    localparam logic [2:0] OP_RECOLOR    = 3'd3;
    localparam logic [2:0] OP_SET_CURSOR = 3'd4;
    localparam logic [2:0] OP_READ_CELL  = 3'd5;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam int         TAB_STOP   = 4;
    localparam int         TAB_BITS   = $clog2(TAB_STOP);

    localparam int         APB_AW           = 3;
    localparam logic       CFG_DEFAULT_ATTR = 1'b0;

endpackage

// ----- src/tcw_store.sv -----
// ----------------------------------------------------------------------------
// tcw_store: character and attribute screen memories
// One write port with separate enables and one registered read port.
// ----------------------------------------------------------------------------
module tcw_store
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  t_mem_we       i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wchar,
    input  logic [7:0]    i_wattr,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rchar,
    output logic [7:0]    o_rattr
);

    logic [7:0] r_char_mem [DEPTH];
    logic [7:0] r_attr_mem [DEPTH];
    logic [7:0] r_rchar;
    logic [7:0] r_rattr;

    always_ff @(posedge i_clk) begin
        if (i_we.chr) begin
            r_char_mem[i_waddr] <= i_wchar;
        end
        if (i_we.atr) begin
            r_attr_mem[i_waddr] <= i_wattr;
        end
        r_rchar <= r_char_mem[i_raddr];
        r_rattr <= r_attr_mem[i_raddr];
    end

    assign o_rchar = r_rchar;
    assign o_rattr = r_rattr;

endmodule

// ----- src/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl: operation sequencer and cursor of the text console writer
// Decodes one operation, drives the screen memory sweeps and forms the result.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_item      i_in_data,
    input  logic [7:0]    i_default_attr,
    input  logic          i_res_free,
    output logic          o_res_valid,
    output t_out_item     o_res,
    output t_mem_we       o_mem_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wchar,
    output logic [7:0]    o_wattr,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rchar,
    input  logic [7:0]    i_rattr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_idx, n_idx;
    logic [7:0]    r_ch, n_ch;
    logic [7:0]    r_attr, n_attr;
    logic          r_with_attr, n_with_attr;
    logic          r_tab, n_tab;
    logic          r_fill_chr, n_fill_chr;
    logic [7:0]    r_fill_attr, n_fill_attr;
    logic          r_scrolled, n_scrolled;
    logic [7:0]    r_rc, n_rc;
    logic [7:0]    r_ra, n_ra;

    logic [CW-1:0] clamp_col;
    logic [RW-1:0] clamp_row;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] sel_addr;
    logic          col_last;
    logic          row_last;
    logic          tab_stop;
    logic          accept;
    logic          is_put;

    assign clamp_col = (int'(i_in_data.col) > COLUMNS - 1) ? COL_LAST : CW'(i_in_data.col);
    assign clamp_row = (int'(i_in_data.row) > ROWS - 1) ? ROW_LAST : RW'(i_in_data.row);
    assign cur_addr  = AW'(r_row) * ROW_STRIDE + AW'(r_col);
    assign sel_addr  = AW'(clamp_row) * ROW_STRIDE + AW'(clamp_col);
    assign col_last  = (r_col == COL_LAST);
    assign row_last  = (r_row == ROW_LAST);
    assign tab_stop  = (r_col[TAB_BITS-1:0] == {TAB_BITS{1'b1}});
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign is_put    = (i_in_data.op == OP_PUT) || (i_in_data.op == OP_PUT_ATTR);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_idx == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (is_put) begin
                        if (i_in_data.ch == CH_NEWLINE) begin
                            n_state = row_last ? S_SCROLL : S_DONE;
                        end else if (i_in_data.ch == CH_RETURN) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_PUT;
                        end
                    end else if (i_in_data.op == OP_CLEAR || i_in_data.op == OP_RECOLOR) begin
                        n_state = S_FILL;
                    end else if (i_in_data.op == OP_READ_CELL) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                if (col_last) begin
                    n_state = row_last ? S_SCROLL : S_DONE;
                end else if (r_tab && !tab_stop) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                if (r_idx == LAST_COPY) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_idx == LAST_CELL) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_idx       = r_idx;
        n_ch        = r_ch;
        n_attr      = r_attr;
        n_with_attr = r_with_attr;
        n_tab       = r_tab;
        n_fill_chr  = r_fill_chr;
        n_fill_attr = r_fill_attr;
        n_scrolled  = r_scrolled;
        n_rc        = r_rc;
        n_ra        = r_ra;
        o_mem_we    = '0;
        o_waddr     = r_idx;
        o_wchar     = '0;
        o_wattr     = r_fill_attr;
        o_raddr     = sel_addr;
        case (r_state)
            S_INIT: begin
                o_mem_we = '{chr: 1'b1, atr: 1'b1};
                o_wattr  = RESET_ATTR;
                n_idx    = (r_idx == LAST_CELL) ? '0 : r_idx + AW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_scrolled  = 1'b0;
                    n_rc        = '0;
                    n_ra        = '0;
                    n_with_attr = (i_in_data.op == OP_PUT_ATTR);
                    n_attr      = i_in_data.attr;
                    n_tab       = (i_in_data.ch == CH_TAB);
                    n_ch        = (i_in_data.ch == CH_TAB) ? CH_SPACE : i_in_data.ch;
                    n_idx       = '0;
                    n_fill_chr  = 1'b1;
                    n_fill_attr = i_default_attr;
                    case (i_in_data.op)
                        OP_PUT, OP_PUT_ATTR: begin
                            if (i_in_data.ch == CH_NEWLINE) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_scrolled = 1'b1;
                                end else begin
                                    n_row = r_row + RW'(1);
                                end
                            end else if (i_in_data.ch == CH_RETURN) begin
                                n_col = '0;
                            end
                        end
                        OP_CLEAR: begin
                            n_col = '0;
                            n_row = '0;
                        end
                        OP_RECOLOR: begin
                            n_fill_chr  = 1'b0;
                            n_fill_attr = i_in_data.attr;
                        end
                        OP_SET_CURSOR: begin
                            n_col = clamp_col;
                            n_row = clamp_row;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUT: begin
                o_mem_we = '{chr: 1'b1, atr: r_with_attr};
                o_waddr  = cur_addr;
                o_wchar  = r_ch;
                o_wattr  = r_attr;
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_scrolled  = 1'b1;
                        n_idx       = '0;
                        n_fill_chr  = 1'b1;
                        n_fill_attr = i_default_attr;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_SCROLL: begin
                o_raddr  = (r_idx == LAST_COPY) ? '0 : r_idx + ROW_STRIDE;
                o_mem_we = '{chr: (r_idx != '0), atr: (r_idx != '0)};
                o_waddr  = r_idx - AW'(1);
                o_wchar  = i_rchar;
                o_wattr  = i_rattr;
                if (r_idx != LAST_COPY) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_FILL: begin
                o_mem_we = '{chr: r_fill_chr, atr: 1'b1};
                if (r_idx != LAST_CELL) begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_READ: begin
                n_rc = i_rchar;
                n_ra = i_rattr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch        <= n_ch;
        r_attr      <= n_attr;
        r_with_attr <= n_with_attr;
        r_tab       <= n_tab;
        r_fill_chr  <= n_fill_chr;
        r_fill_attr <= n_fill_attr;
        r_scrolled  <= n_scrolled;
        r_rc        <= n_rc;
        r_ra        <= n_ra;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{cursor_pos: 11'(cur_addr), cell_char: r_rc,
                           cell_attr: r_ra, scrolled: r_scrolled};

endmodule

// ----- src/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Character and attribute screen memories with a cursor, APB register port.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//   cfg       input      psel penable pwrite pready paddr pwdata prdata
//
// A plain character passes the put state and a read cell the read state; a
// return, a newline that does not scroll, a cursor set or an unknown operation
// goes straight to the result. A tab writes one to four spaces through the write port.
// A scroll copies the screen through the single write port, then fills the new
// bottom row.
// Clear and recolor sweep all CELLS entries, one per cycle.
// After reset a clearing pass over all CELLS entries (2000 by default) runs first.
// Results wait in an output register; a stalled output holds the next result.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic          r_out_valid;
    t_out_item     r_out_data;
    logic [7:0]    r_default_attr;

    logic          res_free;
    logic          res_valid;
    t_out_item     res;
    logic          cfg_write;
    t_mem_we       mem_we;
    logic [AW-1:0] waddr;
    logic [7:0]    wchar;
    logic [7:0]    wattr;
    logic [AW-1:0] raddr;
    logic [7:0]    rchar;
    logic [7:0]    rattr;

    assign res_free  = !r_out_valid || !i_out_stall;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_DEFAULT_ATTR);

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_default_attr (r_default_attr),
        .i_res_free     (res_free),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .o_mem_we       (mem_we),
        .o_waddr        (waddr),
        .o_wchar        (wchar),
        .o_wattr        (wattr),
        .o_raddr        (raddr),
        .i_rchar        (rchar),
        .i_rattr        (rattr)
    );

    tcw_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wchar (wchar),
        .i_wattr (wattr),
        .i_raddr (raddr),
        .o_rchar (rchar),
        .o_rattr (rattr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_default_attr <= RESET_ATTR;
        end else begin
            if (res_valid && res_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                r_default_attr <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_free) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == CFG_DEFAULT_ATTR) ? {24'd0, r_default_attr} : 32'd0;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is still in work");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_out_data.cursor_pos) < CELLS))
        else $error("cursor position beyond the screen");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && r_out_valid && i_out_stall) |=> res_valid)
        else $error("result dropped while the output register was full");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |=> (r_default_attr == $past(pwdata[7:0])))
        else $error("default attribute not updated by a register transfer");

endmodule

// ----- test/text_console_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// A directed script of console operations is followed by random traffic over
// several settings of the default attribute. Each result, from the script or
// from a screen and cursor predictor, is checked against each transfer on the
// output channel while both channels idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLS * ROWS;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_script_row;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_item          in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic [7:0]  scr_char [0:CELLS-1];
    logic [7:0]  scr_attr [0:CELLS-1];
    int          cur_col;
    int          cur_row;
    logic [7:0]  fill_attr;

    t_out_item   pending_reports [$];
    t_out_item   head_report;
    t_script_row script [$];
    int          mismatches = 0;
    int          cycles     = 0;
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done  = 1'b0;
    int          hold_count = 0;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_armed && !hold_done) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch (%s): expected pos %0d char %h attr %h scroll %b,",
                     what, want.cursor_pos, want.cell_char, want.cell_attr, want.scrolled,
                     " got pos %0d char %h attr %h scroll %b",
                     got.cursor_pos, got.cell_char, got.cell_attr, got.scrolled);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_reports.size() == 0) begin
                note_mismatch("transfer with nothing pending", '0, out_data);
            end else begin
                head_report = pending_reports.pop_front();
                if (out_data.cursor_pos !== head_report.cursor_pos
                    || out_data.cell_char !== head_report.cell_char
                    || out_data.cell_attr !== head_report.cell_attr
                    || out_data.scrolled !== head_report.scrolled) begin
                    note_mismatch("result", head_report, out_data);
                end
            end
        end
    end

    function automatic bit settle_cursor();
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS) begin
            for (int k = 0; k < CELLS - COLS; k++) begin
                scr_char[k] = scr_char[k + COLS];
                scr_attr[k] = scr_attr[k + COLS];
            end
            for (int k = CELLS - COLS; k < CELLS; k++) begin
                scr_char[k] = 8'h00;
                scr_attr[k] = fill_attr;
            end
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit place_cell(input logic [7:0] glyph, input bit tinted,
                                      input logic [7:0] tint);
        scr_char[cur_row * COLS + cur_col] = glyph;
        if (tinted) begin
            scr_attr[cur_row * COLS + cur_col] = tint;
        end
        cur_col++;
        return settle_cursor();
    endfunction

    function automatic bit put_glyph(input logic [7:0] glyph, input bit tinted,
                                     input logic [7:0] tint);
        bit hit;
        int spaces;
        int n;
        hit = 1'b0;
        if (glyph == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
            hit = settle_cursor();
        end else if (glyph == CH_RETURN) begin
            cur_col = 0;
        end else if (glyph == CH_TAB) begin
            spaces = TAB_STOP - cur_col % TAB_STOP;
            n = 0;
            do begin
                if (place_cell(CH_SPACE, tinted, tint)) begin
                    hit = 1'b1;
                end
                n++;
            end while (n < spaces && cur_col % TAB_STOP != 0);
        end else begin
            hit = place_cell(glyph, tinted, tint);
        end
        return hit;
    endfunction

    function automatic t_out_item console_step(input t_in_item req);
        t_out_item res;
        int        col_c;
        int        row_c;
        res   = '0;
        col_c = (req.col > COLS - 1) ? COLS - 1 : int'(req.col);
        row_c = (req.row > ROWS - 1) ? ROWS - 1 : int'(req.row);
        case (req.op)
            OP_PUT, OP_PUT_ATTR: begin
                res.scrolled = put_glyph(req.ch, req.op == OP_PUT_ATTR, req.attr);
            end
            OP_CLEAR: begin
                for (int k = 0; k < CELLS; k++) begin
                    scr_char[k] = 8'h00;
                    scr_attr[k] = fill_attr;
                end
                cur_col = 0;
                cur_row = 0;
            end
            OP_RECOLOR: begin
                for (int k = 0; k < CELLS; k++) begin
                    scr_attr[k] = req.attr;
                end
            end
            OP_SET_CURSOR: begin
                cur_col = col_c;
                cur_row = row_c;
            end
            OP_READ_CELL: begin
                res.cell_char = scr_char[row_c * COLS + col_c];
                res.cell_attr = scr_attr[row_c * COLS + col_c];
            end
            default: begin
            end
        endcase
        res.cursor_pos = 11'(cur_row * COLS + cur_col);
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int       pick;
        pick     = $urandom_range(999);
        req.op   = OP_PUT;
        req.ch   = 8'($urandom);
        req.attr = 8'($urandom);
        req.col  = 7'($urandom);
        req.row  = 5'($urandom);
        if (pick < 430) begin
            req.op = OP_PUT;
        end else if (pick < 620) begin
            req.op = OP_PUT_ATTR;
        end else if (pick < 700) begin
            req.op = pick[0] ? OP_PUT : OP_PUT_ATTR;
            req.ch = CH_NEWLINE;
        end else if (pick < 740) begin
            req.op = pick[0] ? OP_PUT : OP_PUT_ATTR;
            req.ch = CH_RETURN;
        end else if (pick < 800) begin
            req.op = pick[0] ? OP_PUT : OP_PUT_ATTR;
            req.ch = CH_TAB;
        end else if (pick < 870) begin
            req.op = OP_SET_CURSOR;
            if (pick < 850) begin
                req.col = 7'($urandom_range(COLS - 1));
                req.row = 5'($urandom_range(ROWS - 1, ROWS - 7));
            end
        end else if (pick < 950) begin
            req.op = OP_READ_CELL;
            if (pick < 930) begin
                req.col = 7'($urandom_range(COLS - 1));
                req.row = 5'($urandom_range(ROWS - 1));
            end
        end else if (pick < 965) begin
            req.op = OP_CLEAR;
        end else if (pick < 980) begin
            req.op = OP_RECOLOR;
        end else begin
            req.op = pick[0] ? OP_RESERVED_A : OP_RESERVED_B;
        end
        return req;
    endfunction

    function automatic t_script_row script_row(
        input logic [2:0] op, input logic [7:0] ch, input logic [7:0] attr,
        input logic [6:0] col, input logic [4:0] row, input logic typed,
        input logic [10:0] pos, input logic [7:0] cell_ch, input logic [7:0] cell_at,
        input logic scrolled);
        t_script_row r;
        r.item  = '{op: op, ch: ch, attr: attr, col: col, row: row};
        r.typed = typed;
        r.want  = '{cursor_pos: pos, cell_char: cell_ch, cell_attr: cell_at,
                    scrolled: scrolled};
        return r;
    endfunction

    task automatic offer(input t_in_item req, input logic typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predicted = console_step(req);
        pending_reports.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic program_default_attr(input logic [7:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'({CFG_DEFAULT_ATTR, 2'b00});
        pwdata  <= {24'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        fill_attr = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (readback[7:0] !== value) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch (register read): expected %h, got %h", value, readback[7:0]);
            end
        end
    endtask

    task automatic run_traffic(input int count);
        repeat (count) begin
            offer(random_request(), 1'b0, '0);
        end
    endtask

    initial begin
        for (int k = 0; k < CELLS; k++) begin
            scr_char[k] = 8'h00;
            scr_attr[k] = RESET_ATTR;
        end
        cur_col   = 0;
        cur_row   = 0;
        fill_attr = RESET_ATTR;

        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd0, 8'h00, 8'h07, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd127, 5'd31,
                                    1'b1, 11'd0, 8'h00, 8'h07, 1'b0));
        script.push_back(script_row(OP_PUT, 8'd65, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT_ATTR, 8'hFF, 8'hFF, 7'd0, 5'd0,
                                    1'b1, 11'd2, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd1, 5'd0,
                                    1'b1, 11'd2, 8'hFF, 8'hFF, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd2, 8'd65, 8'h07, 1'b0));
        script.push_back(script_row(OP_PUT, CH_TAB, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd4, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT_ATTR, CH_TAB, 8'h5A, 7'd0, 5'd0,
                                    1'b1, 11'd8, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT, CH_RETURN, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd0, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd80, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_SET_CURSOR, 8'h00, 8'h00, 7'd127, 5'd31,
                                    1'b1, 11'd1999, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT_ATTR, 8'd90, 8'hC3, 7'd0, 5'd0,
                                    1'b1, 11'd1920, 8'h00, 8'h00, 1'b1));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd23,
                                    1'b1, 11'd1920, 8'd90, 8'hC3, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd24,
                                    1'b1, 11'd1920, 8'h00, 8'h07, 1'b0));
        script.push_back(script_row(OP_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1920, 8'h00, 8'h00, 1'b1));
        script.push_back(script_row(OP_SET_CURSOR, 8'h00, 8'h00, 7'd78, 5'd24,
                                    1'b1, 11'd1998, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT, CH_TAB, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1920, 8'h00, 8'h00, 1'b1));
        script.push_back(script_row(OP_RECOLOR, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1920, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1920, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_SET_CURSOR, 8'h00, 8'h00, 7'd80, 5'd25,
                                    1'b0, '0, '0, '0, 1'b0));
        script.push_back(script_row(OP_SET_CURSOR, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd0, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_RESERVED_A, 8'hFF, 8'hFF, 7'd127, 5'd31,
                                    1'b1, 11'd0, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_RESERVED_B, 8'hFF, 8'hFF, 7'd127, 5'd31,
                                    1'b1, 11'd0, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_PUT_ATTR, 8'd81, 8'hA5, 7'd0, 5'd0,
                                    1'b1, 11'd1, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd0, 8'h00, 8'h00, 1'b0));
        script.push_back(script_row(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd0, 8'h00, 8'h07, 1'b0));
        script.push_back(script_row(OP_PUT, 8'h00, 8'h00, 7'd0, 5'd0,
                                    1'b1, 11'd1, 8'h00, 8'h00, 1'b0));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct   = 27;
        stall_pct = 49;
        foreach (script[i]) begin
            offer(script[i].item, script[i].typed, script[i].want);
        end
        drain();

        program_default_attr(8'h00);
        run_traffic(PHASE_ITEMS);
        drain();

        program_default_attr(8'hFF);
        gap_pct   = 49;
        stall_pct = 27;
        run_traffic(PHASE_ITEMS);
        drain();

        program_default_attr(8'($urandom_range(254, 1)));
        gap_pct    = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        run_traffic(PHASE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
